// ===== hdl/u8d_pkg.sv =====
// Shared types, codes and constants for the UTF-8 byte stream decoder.
`default_nettype none
package u8d_pkg;

  // Default queue depths (powers of two)
  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned OutDepthDefault   = 2;

  localparam int unsigned CpWidth = 21;

  // Byte classes found by the front end
  localparam logic [2:0] CLS_ASCII = 3'd0;
  localparam logic [2:0] CLS_LEAD2 = 3'd1;
  localparam logic [2:0] CLS_LEAD3 = 3'd2;
  localparam logic [2:0] CLS_LEAD4 = 3'd3;
  localparam logic [2:0] CLS_BAD   = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD  = 2'd1;
  localparam logic [1:0] ST_TRUNC     = 2'd2;
  localparam logic [1:0] ST_DISCARDED = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic [1:0]         status;
    logic               text_done;
  } out_item_t;

  // Classified byte handed from front to back
  typedef struct packed {
    logic [2:0]         cls;
    logic [CpWidth-1:0] lead_point;
    logic [5:0]         cont_bits;
    logic               eot;
  } cls_item_t;

endpackage : u8d_pkg
`default_nettype wire

// ===== hdl/utf8_byte_stream_decoder.sv =====
// Top level of the UTF-8 byte stream decoder: front, queue, back and result queue.
// Throughput: one byte per cycle sustained, with both sides free to stall on their own.
// A result is visible once its byte has passed the front register, the queue and the back
// end's write into the result queue, later while the queues hold backlog.
// Reset: synchronous rst empties both queues and clears the sequence state.
`default_nettype none
module utf8_byte_stream_decoder
  import u8d_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned OUT_DEPTH   = OutDepthDefault
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  input  wire in_item_t item,
  output logic          full,
  output out_item_t     result,
  output logic          empty,
  input  wire           pop
);

  logic      q_wr;
  cls_item_t q_wdata;
  logic      q_full;
  logic      q_rd;
  cls_item_t q_rdata;
  logic      q_empty;
  logic      res_wr;
  out_item_t res_wdata;
  logic      res_full;

  // Accept and classify bytes
  u8d_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_wr   (q_wr),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  // Decouple front and back
  u8d_fifo #(
    .item_t (cls_item_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // Decode sequences
  u8d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_rd     (q_rd),
    .res_wr   (res_wr),
    .res_data (res_wdata),
    .res_full (res_full)
  );

  // Hold results until popped
  u8d_fifo #(
    .item_t (out_item_t),
    .DEPTH  (OUT_DEPTH)
  ) u_results (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data (res_wdata),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule : utf8_byte_stream_decoder
`default_nettype wire

// ===== hdl/u8d_fifo.sv =====
// Small register queue used between front and back and at the result side.
`default_nettype none
module u8d_fifo
  import u8d_pkg::*;
#(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = 4
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        wr_en,
  input  wire item_t wr_data,
  output logic       full,
  input  wire        rd_en,
  output item_t      rd_data,
  output logic       empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  logic do_wr;
  logic do_rd;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store a beat at the tail
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : u8d_fifo
`default_nettype wire

// ===== hdl/u8d_front.sv =====
// Front end: accepts bytes, classifies lead patterns and registers the result.
`default_nettype none
module u8d_front
  import u8d_pkg::*;
(
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  input  wire in_item_t item,
  output logic          full,
  output logic          q_wr,
  output cls_item_t     q_data,
  input  wire           q_full
);

  logic      front_valid;
  logic      front_valid_next;
  cls_item_t front_item;
  cls_item_t cls_next;
  logic      take;

  assign q_wr   = front_valid && !q_full;
  assign q_data = front_item;
  assign full   = front_valid && q_full;
  assign take   = push && !full;

  // Classify the byte and place lead payload bits
  always_comb begin
    cls_next            = '0;
    cls_next.eot        = item.end_of_text;
    cls_next.cont_bits  = item.text_byte[5:0];
    priority if (item.text_byte[7] == 1'b0) begin
      cls_next.cls        = CLS_ASCII;
      cls_next.lead_point = CpWidth'(item.text_byte);
    end else if (item.text_byte[7:5] == 3'b110) begin
      cls_next.cls        = CLS_LEAD2;
      cls_next.lead_point = CpWidth'({item.text_byte[4:0], 6'b0});
    end else if (item.text_byte[7:4] == 4'b1110) begin
      cls_next.cls        = CLS_LEAD3;
      cls_next.lead_point = CpWidth'({item.text_byte[3:0], 12'b0});
    end else if (item.text_byte[7:3] == 5'b11110) begin
      cls_next.cls        = CLS_LEAD4;
      cls_next.lead_point = CpWidth'({item.text_byte[2:0], 18'b0});
    end else begin
      cls_next.cls        = CLS_BAD;
      cls_next.lead_point = '0;
    end
  end

  // Hold the stage until the queue takes it
  always_comb begin
    front_valid_next = front_valid;
    if (take) begin
      front_valid_next = 1'b1;
    end else if (q_wr) begin
      front_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= front_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      front_item <= cls_next;
    end
  end

endmodule : u8d_front
`default_nettype wire

// ===== hdl/u8d_back.sv =====
// Back end: sequence state, code point assembly and result generation.
`default_nettype none
module u8d_back
  import u8d_pkg::*;
(
  input  wire            clk,
  input  wire            rst,
  input  wire            q_empty,
  input  wire cls_item_t q_data,
  output logic           q_rd,
  output logic           res_wr,
  output out_item_t      res_data,
  input  wire            res_full
);

  logic [1:0]         bytes_remaining;
  logic [1:0]         bytes_remaining_next;
  logic [CpWidth-1:0] partial_point;
  logic [CpWidth-1:0] partial_point_next;
  logic               discarding;
  logic               discarding_next;
  logic               emit;
  logic [CpWidth-1:0] merged;
  logic [CpWidth-1:0] cont_shifted;

  assign q_rd   = !q_empty && !res_full;
  assign res_wr = q_rd && emit;

  // Place continuation bits by how many bytes remain
  always_comb begin
    unique case (bytes_remaining)
      2'd2:    cont_shifted = CpWidth'({q_data.cont_bits, 6'b0});
      2'd3:    cont_shifted = CpWidth'({q_data.cont_bits, 12'b0});
      default: cont_shifted = CpWidth'(q_data.cont_bits);
    endcase
    merged = partial_point | cont_shifted;
  end

  // Step the decoder for one beat
  always_comb begin
    bytes_remaining_next = bytes_remaining;
    partial_point_next   = partial_point;
    discarding_next      = discarding;
    emit                 = 1'b0;
    res_data             = '0;
    res_data.text_done   = q_data.eot;
    if (discarding) begin
      if (q_data.eot) begin
        emit               = 1'b1;
        res_data.status    = ST_DISCARDED;
        discarding_next    = 1'b0;
        partial_point_next = '0;
      end
    end else if (bytes_remaining == 2'd0) begin
      unique case (q_data.cls)
        CLS_ASCII: begin
          emit                = 1'b1;
          res_data.code_point = q_data.lead_point;
          res_data.status     = ST_OK;
        end
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          if (q_data.eot) begin
            emit               = 1'b1;
            res_data.status    = ST_TRUNC;
            partial_point_next = '0;
          end else begin
            partial_point_next   = q_data.lead_point;
            bytes_remaining_next = (q_data.cls == CLS_LEAD2) ? 2'd1 :
                                   (q_data.cls == CLS_LEAD3) ? 2'd2 : 2'd3;
          end
        end
        default: begin
          emit               = 1'b1;
          res_data.status    = ST_BAD_LEAD;
          partial_point_next = '0;
          discarding_next    = !q_data.eot;
        end
      endcase
    end else begin
      bytes_remaining_next = bytes_remaining - 2'd1;
      if (bytes_remaining == 2'd1) begin
        emit                = 1'b1;
        res_data.code_point = merged;
        res_data.status     = ST_OK;
        partial_point_next  = '0;
      end else if (q_data.eot) begin
        emit                 = 1'b1;
        res_data.status      = ST_TRUNC;
        partial_point_next   = '0;
        bytes_remaining_next = 2'd0;
      end else begin
        partial_point_next = merged;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      partial_point   <= '0;
      discarding      <= 1'b0;
    end else if (q_rd) begin
      bytes_remaining <= bytes_remaining_next;
      partial_point   <= partial_point_next;
      discarding      <= discarding_next;
    end
  end

  // Discard mode only starts from an idle sequence
  a_discard_idle: assert property (@(posedge clk) disable iff (rst)
    discarding |-> (bytes_remaining == 2'd0))
    else $error("discarding while a sequence is open");

  // Text end leaves all state clear
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (res_wr && res_data.text_done) |=>
      (bytes_remaining == 2'd0 && partial_point == '0 && !discarding))
    else $error("state not cleared after text end");

  // Error results carry no code point
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_wr && res_data.status != ST_OK) |-> (res_data.code_point == '0))
    else $error("error result with nonzero code point");

  // No beat taken while the result queue is full
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_full |-> !q_rd)
    else $error("beat consumed with result queue full");

endmodule : u8d_back
`default_nettype wire

// ===== tb/utf8_byte_stream_decoder_tb.sv =====
// Self-checking testbench for the UTF-8 byte stream decoder: directed and random texts.
`default_nettype none
module utf8_byte_stream_decoder_tb
  import u8d_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  in_item_t  item = '0;
  logic      full;
  out_item_t result;
  logic      empty;
  logic      pop = 1'b0;

  // Decoder state as the testbench sees it
  logic [1:0]          seq_left = '0;
  logic [CpWidth-1:0]  cp_accum = '0;
  logic                skipping = 1'b0;

  out_item_t expected_points[$];
  int        beats_in = 0;
  int        beats_sent = 0;
  int        mismatches = 0;

  utf8_byte_stream_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the decoder state by one byte; return 1 when a code point or status comes out
  function automatic bit decode_byte(input logic [7:0] b, input logic eot,
                                     output out_item_t res);
    res = '0;
    if (skipping) begin
      if (eot) begin
        seq_left = '0;
        cp_accum = '0;
        skipping = 1'b0;
        res.status = ST_DISCARDED;
        res.text_done = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (seq_left == 2'd0) begin
      if (!b[7]) begin
        res.code_point = CpWidth'(b);
        res.status = ST_OK;
        res.text_done = eot;
        return 1'b1;
      end else if (b[7:5] == 3'b110) begin
        cp_accum = CpWidth'(b[4:0]) << 6;
        seq_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cp_accum = CpWidth'(b[3:0]) << 12;
        seq_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        cp_accum = CpWidth'(b[2:0]) << 18;
        seq_left = 2'd3;
      end else begin
        // bad lead: report once, then drop bytes unless this ends the text
        seq_left = '0;
        cp_accum = '0;
        skipping = !eot;
        res.status = ST_BAD_LEAD;
        res.text_done = eot;
        return 1'b1;
      end
      if (eot) begin
        seq_left = '0;
        cp_accum = '0;
        res.status = ST_TRUNC;
        res.text_done = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    // continuation: only the low six bits count
    cp_accum = cp_accum | (CpWidth'(b[5:0]) << (6 * (seq_left - 2'd1)));
    seq_left = seq_left - 2'd1;
    if (seq_left == 2'd0) begin
      res.code_point = cp_accum;
      res.status = ST_OK;
      res.text_done = eot;
      cp_accum = '0;
      return 1'b1;
    end
    if (eot) begin
      seq_left = '0;
      cp_accum = '0;
      res.status = ST_TRUNC;
      res.text_done = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    mismatches++;
  endtask

  // Predict on every accepted beat
  always @(posedge clk) begin : intake
    out_item_t exp_res;
    if (!rst && push && !full) begin
      beats_in <= beats_in + 1;
      if (decode_byte(item.text_byte, item.end_of_text, exp_res))
        expected_points.push_back(exp_res);
    end
  end

  // Compare every popped result with the oldest prediction
  always @(posedge clk) begin : check
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected result", int'(result), 0);
      end else begin
        want = expected_points.pop_front();
        if (result.code_point !== want.code_point)
          report_mismatch("code_point", int'(result.code_point), int'(want.code_point));
        if (result.status !== want.status)
          report_mismatch("status", int'(result.status), int'(want.status));
        if (result.text_done !== want.text_done)
          report_mismatch("text_done", int'(result.text_done), int'(want.text_done));
      end
    end
  end

  // Receiver: runs of pops broken by stalls, sometimes long runs with no stall
  initial begin : sink
    int run;
    int hold;
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      pop <= 1'b1;
      repeat (run) @(posedge clk);
      hold = idle_len();
      if (hold > 0) begin
        pop <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Send one beat, hold until it is taken, then idle for gap cycles
  task automatic send_beat(input logic [7:0] b, input logic eot, input int gap);
    int target;
    target = beats_in + 1;
    push <= 1'b1;
    item <= '{text_byte: b, end_of_text: eot};
    wait (beats_in == target);
    beats_sent++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send a whole text with the end flag on its last byte
  task automatic send_text(input logic [7:0] bytes[$], input bit burst);
    foreach (bytes[i])
      send_beat(bytes[i], i == bytes.size() - 1, burst ? 0 : idle_len());
  endtask

  task automatic test_ascii();
    send_text('{8'h00, 8'h7F}, 1'b0);
  endtask

  // Largest two- and four-byte points, an overlong form, a three-byte form with continuations 0xC0 and 0xFF
  task automatic test_multibyte();
    send_text('{8'hDF, 8'hBF, 8'hC0, 8'h80, 8'hEF, 8'hC0, 8'hFF,
                8'hF7, 8'hBF, 8'hBF, 8'hBF}, 1'b1);
  endtask

  // Bad lead at a text's start then discard to the end; bad lead as the final byte
  task automatic test_bad_lead();
    send_text('{8'h80, 8'h41, 8'hF8}, 1'b0);
    send_text('{8'hFF}, 1'b0);
  endtask

  // Text ends on a lead or inside a sequence
  task automatic test_truncated();
    send_text('{8'hC3}, 1'b0);
    send_text('{8'hE2, 8'h82}, 1'b0);
    send_text('{8'hF0, 8'h9F, 8'h98}, 1'b0);
  endtask

  // Hold the sender until every result has drained, then carry on
  task automatic test_drain_pause();
    push <= 1'b0;
    @(posedge clk);
    wait (expected_points.size() == 0);
    send_text('{8'hF0, 8'h9F, 8'h98, 8'h80}, 1'b1);
  endtask

  // Random texts: mostly well formed, some with bad leads, truncation or noise
  task automatic test_random_texts(input int n_beats);
    logic [7:0] text[$];
    int kind;
    int n_chars;
    int bad_at;
    int len;
    int n_cont;
    while (beats_sent < n_beats) begin
      text.delete();
      kind = $urandom_range(0, 9);
      n_chars = $urandom_range(1, 10);
      bad_at = $urandom_range(0, n_chars - 1);
      if (kind == 9) begin
        repeat ($urandom_range(1, 8)) text.push_back(8'($urandom));
      end else begin
        for (int c = 0; c < n_chars; c++) begin
          if (kind == 7 && c == bad_at)
            text.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                : 8'($urandom_range(8'hF8, 8'hFF)));
          len = (kind == 8 && c == n_chars - 1) ? $urandom_range(2, 4) : $urandom_range(1, 4);
          n_cont = (kind == 8 && c == n_chars - 1) ? $urandom_range(0, len - 2) : len - 1;
          case (len)
            1: text.push_back({1'b0, 7'($urandom)});
            2: text.push_back({3'b110, 5'($urandom)});
            3: text.push_back({4'b1110, 4'($urandom)});
            default: text.push_back({5'b11110, 3'($urandom)});
          endcase
          for (int k = 0; k < n_cont; k++)
            text.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                         : {2'b10, 6'($urandom)});
        end
      end
      send_text(text, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) begin
        push <= 1'b0;
        @(posedge clk);
        wait (expected_points.size() == 0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_ascii();
    test_multibyte();
    test_bad_lead();
    test_truncated();
    test_drain_pause();
    test_random_texts(beats_sent + 420);
    push <= 1'b0;
    wait (expected_points.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule : utf8_byte_stream_decoder_tb
`default_nettype wire

// ===== utf8_byte_stream_decoder.f =====
hdl/u8d_pkg.sv
hdl/u8d_fifo.sv
hdl/u8d_front.sv
hdl/u8d_back.sv
hdl/utf8_byte_stream_decoder.sv
tb/utf8_byte_stream_decoder_tb.sv
